// ===== design/vtgd_pkg.sv =====
// ----------------------------------------------------------------------------
// vtgd_pkg
// Shared types and constants for the vector tile geometry decoder.
// ----------------------------------------------------------------------------
package vtgd_pkg;

    localparam int COORD_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [2:0] CMD_MOVE  = 3'd1;
    localparam logic [2:0] CMD_LINE  = 3'd2;
    localparam logic [2:0] CMD_CLOSE = 3'd7;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_POINT   = 2'd1,
        KIND_LINE    = 2'd2,
        KIND_POLYGON = 2'd3
    } geom_kind_t;

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_DX  = 2'd1,
        PH_DY  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_VERTEX = 3'd0,
        EV_START  = 3'd1,
        EV_CLOSE  = 3'd2,
        EV_BADCMD = 3'd3,
        EV_EMPTY  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_DELTA_X = 3'd1,
        OP_VERTEX  = 3'd2,
        OP_CLOSE   = 3'd3,
        OP_EVENT   = 3'd4
    } op_kind_t;

    // work item handed from the decoder to the datapath
    typedef struct packed {
        op_kind_t    kind;
        logic        clear;      // feature start: zero position and path origin first
        event_t      ev;
        logic        set_first;  // latch new position as path origin
        logic [31:0] word;       // raw zigzag delta
    } op_t;

endpackage

// ===== design/vtgd_front.sv =====
// ----------------------------------------------------------------------------
// vtgd_front
// Command decoder: tracks phase, command and repeat count, and turns each
// geometry word into a datapath operation.
// ----------------------------------------------------------------------------
module vtgd_front
    import vtgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [31:0] geometry_word,
    input  logic        feature_start,
    input  logic [1:0]  geometry_kind,
    output logic        push,
    output op_t         push_op
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [28:0] count_reg, count_next;
    logic        has_pts_reg, has_pts_next;

    phase_t      eff_phase;
    logic [2:0]  eff_cmd;
    logic [28:0] eff_count;
    logic        eff_pts;
    logic [28:0] count_dec;
    logic [2:0]  word_cmd;
    logic [28:0] word_count;
    logic        shaped;
    logic        known;
    op_t         op;

    // feature start clears the decoder before the word is looked at
    assign eff_phase  = feature_start ? PH_CMD : phase_reg;
    assign eff_cmd    = feature_start ? 3'd0   : cmd_reg;
    assign eff_count  = feature_start ? '0     : count_reg;
    assign eff_pts    = feature_start ? 1'b0   : has_pts_reg;
    assign count_dec  = eff_count - 29'd1;
    assign word_cmd   = geometry_word[2:0];
    assign word_count = geometry_word[31:3];
    assign shaped     = geometry_kind inside {KIND_LINE, KIND_POLYGON};
    assign known      = (geometry_kind != KIND_UNKNOWN);

    always_comb
    begin : next_state
        phase_next = phase_reg;
        if (accept)
        begin
            if (!known)
            begin
                phase_next = eff_phase;
            end
            else
            begin
                case (eff_phase)
                    PH_DX:   phase_next = PH_DY;
                    PH_DY:   phase_next = (count_dec != '0) ? PH_DX : PH_CMD;
                    default:
                    begin
                        if ((word_count != '0) && (word_cmd inside {CMD_MOVE, CMD_LINE}))
                            phase_next = PH_DX;
                        else
                            phase_next = PH_CMD;
                    end
                endcase
            end
        end
    end

    always_comb
    begin : outputs
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        has_pts_next  = has_pts_reg;
        op.kind       = OP_NONE;
        op.clear      = feature_start;
        op.ev         = EV_VERTEX;
        op.set_first  = 1'b0;
        op.word       = geometry_word;
        if (accept)
        begin
            cmd_next     = eff_cmd;
            count_next   = eff_count;
            has_pts_next = eff_pts;
            if (known)
            begin
                case (eff_phase)
                    PH_DX:
                    begin
                        op.kind = OP_DELTA_X;
                    end
                    PH_DY:
                    begin
                        count_next = count_dec;
                        op.kind    = OP_VERTEX;
                        if (shaped)
                        begin
                            has_pts_next = 1'b1;
                            if (eff_cmd == CMD_MOVE)
                            begin
                                op.ev        = EV_START;
                                op.set_first = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        cmd_next   = word_cmd;
                        count_next = word_count;
                        if (word_count != '0)
                        begin
                            if (word_cmd == CMD_CLOSE)
                            begin
                                count_next = '0;
                                if (shaped)
                                begin
                                    op.kind = eff_pts ? OP_CLOSE : OP_EVENT;
                                    op.ev   = eff_pts ? EV_CLOSE : EV_EMPTY;
                                    has_pts_next = 1'b0;
                                end
                            end
                            else if (!(word_cmd inside {CMD_MOVE, CMD_LINE}))
                            begin
                                count_next = '0;
                                op.kind    = OP_EVENT;
                                op.ev      = EV_BADCMD;
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign push    = accept && ((op.kind != OP_NONE) || feature_start);
    assign push_op = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CMD;
            cmd_reg     <= '0;
            count_reg   <= '0;
            has_pts_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            count_reg   <= count_next;
            has_pts_reg <= has_pts_next;
        end
    end

    // a dy word is only expected while repetitions remain
    a_dy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DY) |-> (count_reg != '0))
        else $error("dy phase with zero remaining count");

    // a close consumes the open path
    a_close_clears_path: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_op.kind == OP_CLOSE)) |=> !has_pts_reg)
        else $error("path still marked non-empty after close");

endmodule

// ===== design/vtgd_queue.sv =====
// ----------------------------------------------------------------------------
// vtgd_queue
// Short register queue of operations between decoder and datapath.
// ----------------------------------------------------------------------------
module vtgd_queue
    import vtgd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    output logic pop_valid,
    output op_t  pop_op,
    input  logic pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(QUEUE_DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue underflow");

endmodule

// ===== design/vtgd_back.sv =====
// ----------------------------------------------------------------------------
// vtgd_back
// Coordinate datapath: zigzag decode, position accumulate, path origin and
// the registered result beat.
// ----------------------------------------------------------------------------
module vtgd_back
    import vtgd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  op_t         op,
    output logic        op_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] vertex_x,
    output logic [31:0] vertex_y,
    output logic [2:0]  event_kind
);

    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic [31:0]           pdx_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_x_reg, out_y_reg;
    event_t                out_ev_reg;

    logic [COORD_BITS-1:0] base_x, base_y;
    logic [COORD_BITS-1:0] delta_x, delta_y;
    logic [COORD_BITS-1:0] sum_x, sum_y;
    logic                  fire;

    // zigzag decode, then sign extend or wrap to the coordinate width
    function automatic logic [COORD_BITS-1:0] unzigzag(input logic [31:0] w);
        logic [31:0] d;
        logic [63:0] d64;
        d   = (w >> 1) ^ {32{w[0]}};
        d64 = {{32{d[31]}}, d};
        return d64[COORD_BITS-1:0];
    endfunction

    function automatic logic [31:0] to_out(input logic [COORD_BITS-1:0] v);
        logic [63:0] v64;
        for (int i = 0; i < COORD_BITS; i++)
            v64[i] = v[i];
        for (int i = COORD_BITS; i < 64; i++)
            v64[i] = v[COORD_BITS-1];
        return v64[31:0];
    endfunction

    assign fire    = op_valid && (!out_valid_reg || out_ready);
    assign op_pop  = fire;
    assign base_x  = op.clear ? '0 : pos_x_reg;
    assign base_y  = op.clear ? '0 : pos_y_reg;
    assign delta_x = unzigzag(pdx_reg);
    assign delta_y = unzigzag(op.word);
    assign sum_x   = base_x + delta_x;
    assign sum_y   = base_y + delta_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= op.kind inside {OP_VERTEX, OP_CLOSE, OP_EVENT};
                // a clear only rides on command words, never on a vertex
                if (op.kind == OP_VERTEX)
                begin
                    pos_x_reg <= sum_x;
                    pos_y_reg <= sum_y;
                    if (op.set_first)
                    begin
                        first_x_reg <= sum_x;
                        first_y_reg <= sum_y;
                    end
                end
                else if (op.clear)
                begin
                    pos_x_reg   <= '0;
                    pos_y_reg   <= '0;
                    first_x_reg <= '0;
                    first_y_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_ev_reg <= op.ev;
            case (op.kind)
                OP_DELTA_X:
                begin
                    pdx_reg <= op.word;
                end
                OP_VERTEX:
                begin
                    out_x_reg <= to_out(sum_x);
                    out_y_reg <= to_out(sum_y);
                end
                OP_CLOSE:
                begin
                    out_x_reg <= to_out(op.clear ? '0 : first_x_reg);
                    out_y_reg <= to_out(op.clear ? '0 : first_y_reg);
                end
                default:
                begin
                    out_x_reg <= '0;
                    out_y_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign vertex_x   = out_x_reg;
    assign vertex_y   = out_y_reg;
    assign event_kind = out_ev_reg;

    a_error_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_ev_reg == EV_BADCMD) || (out_ev_reg == EV_EMPTY)))
        |-> ((out_x_reg == '0) && (out_y_reg == '0)))
        else $error("error event with nonzero coordinates");

    a_vertex_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (op.kind == OP_VERTEX)) |=> out_valid_reg)
        else $error("vertex operation produced no beat");

endmodule

// ===== design/vector_tile_geometry_decoder.sv =====
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder
// Decodes a vector tile geometry word stream into vertices and path events.
// ----------------------------------------------------------------------------
// Takes one geometry word per cycle while the queue is not full and returns
// at most one beat per word: a vertex (plain, path start or closing) or an
// error event (unknown command, close on an empty path). The decoder
// classifies each word and queues an operation; the datapath does the
// zigzag decode and add for both axes per vertex, so the block sustains
// one word per clock until the queue fills. A four-entry queue and the
// output register absorb back pressure without stalling the input at once.
module vector_tile_geometry_decoder
    import vtgd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] geometry_word
    input  logic [2:0]  s_axis_tuser,   // [0] feature_start, [2:1] geometry_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] vertex_x, [63:32] vertex_y
    output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

    logic        accept;
    logic        push;
    op_t         push_op;
    logic        full;
    logic        q_valid;
    op_t         q_op;
    logic        q_pop;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [2:0]  event_kind;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    vtgd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .geometry_word (s_axis_tdata),
        .feature_start (s_axis_tuser[0]),
        .geometry_kind (s_axis_tuser[2:1]),
        .push          (push),
        .push_op       (push_op)
    );

    vtgd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (full),
        .pop_valid (q_valid),
        .pop_op    (q_op),
        .pop       (q_pop)
    );

    vtgd_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (q_valid),
        .op         (q_op),
        .op_pop     (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .event_kind (event_kind)
    );

    assign m_axis_tdata = {vertex_y, vertex_x};
    assign m_axis_tuser = event_kind;

endmodule
